@@ rtl/rlps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rlps_pkg
// Shared types and constants of the run-length palette sprite decoder.
// ----------------------------------------------------------------------------
package rlps_pkg;

  localparam int DEF_PALETTE_BANKS = 10;
  localparam int DEF_COORD_BITS    = 16;

  localparam int BANK_SIZE       = 256;
  localparam int PAL_ADDR_BITS   = 12;
  localparam int COLOR_BITS      = 15;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 16;
  localparam int S_TDATA_BITS    = 40;
  localparam int S_TUSER_BITS    = 2;
  localparam int M_TDATA_BITS    = 56;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PLAYER_BANK  = 2'd2;

  // header types
  localparam logic [2:0] HDR_LITERAL = 3'd0;
  localparam logic [2:0] HDR_SKIP    = 3'd1;
  localparam logic [2:0] HDR_REPEAT  = 3'd2;
  localparam logic [2:0] HDR_NEWLINE = 3'd4;

  typedef struct packed {
    logic                     we;
    logic [PAL_ADDR_BITS-1:0] waddr;
    logic [COLOR_BITS-1:0]    wdata;
    logic                     re;
    logic [PAL_ADDR_BITS-1:0] raddr;
  } pal_req_t;

endpackage
`default_nettype wire

@@ rtl/rlps_palette.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rlps_palette
// Palette memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rlps_palette
  import rlps_pkg::*;
#(
  parameter int PALETTE_BANKS = DEF_PALETTE_BANKS
) (
  input  wire logic                  clk,
  input  wire pal_req_t              req,
  output logic      [COLOR_BITS-1:0] rdata
);

  localparam int DEPTH  = PALETTE_BANKS * BANK_SIZE;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [COLOR_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[ADDR_W-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr[ADDR_W-1:0]];
    end
  end

endmodule
`default_nettype wire

@@ rtl/rlps_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rlps_seq
// Decode sequencer: header parsing, position stepping and pixel output.
// ----------------------------------------------------------------------------
module rlps_seq
  import rlps_pkg::*;
#(
  parameter int PALETTE_BANKS = DEF_PALETTE_BANKS,
  parameter int COORD_BITS    = DEF_COORD_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic  [S_TDATA_BITS-1:0] s_axis_tdata,
  input  wire logic  [S_TUSER_BITS-1:0] s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output logic       [M_TDATA_BITS-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,
  input  wire logic              [15:0] image_width,
  input  wire logic              [15:0] image_height,
  input  wire logic               [3:0] player_bank,
  output pal_req_t                      pal_req,
  input  wire logic    [COLOR_BITS-1:0] pal_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SKIP,
    S_LITPIX,
    S_RUN
  } state_t;

  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_LITERAL,
    MODE_REPEAT
  } mode_t;

  state_t                  state;
  mode_t                   mode;
  logic [COORD_BITS-1:0]   cur_x;
  logic [COORD_BITS-1:0]   cur_y;
  logic [5:0]              run_remaining;
  logic [5:0]              run_length;
  logic [5:0]              cnt;
  logic [7:0]              byte_q;

  logic                    s_fire;
  logic                    is_pal;
  logic                    start;
  logic [PAL_ADDR_BITS-1:0] in_pal_index;
  logic                    x_in;
  logic [COORD_BITS-1:0]   x_inc;
  logic                    x_inc_in;
  logic                    y_done;
  logic                    bank_ok;
  logic                    out_free;
  logic                    out_load;
  logic [2:0]              hdr_type;
  logic [5:0]              hdr_len;
  logic                    lit_over;
  logic [5:0]              cnt_inc;
  logic                    run_done;
  logic                    lit_end;
  logic [M_TDATA_BITS-1:0] pix_word;

  assign s_axis_tready = (state == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign is_pal        = s_axis_tuser[0];
  assign start         = s_axis_tuser[1];
  assign in_pal_index  = s_axis_tdata[19:8];

  assign x_in     = 16'(cur_x) < image_width;
  assign x_inc    = cur_x + 1'b1;
  assign x_inc_in = 16'(x_inc) < image_width;
  assign y_done   = 16'(cur_y) >= image_height;
  assign bank_ok  = {1'b0, player_bank} < 5'(PALETTE_BANKS);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = ((state == S_LITPIX) || (state == S_RUN)) && out_free;
  assign hdr_type = byte_q[7:5];
  assign hdr_len  = {1'b0, byte_q[4:0]} + 6'd1;
  assign lit_over = (mode == MODE_LITERAL) && !x_in;
  assign cnt_inc  = cnt + 6'd1;
  assign run_done = (cnt_inc >= run_length) || !x_inc_in;
  assign lit_end  = (run_remaining == 6'd1) || !x_inc_in;

  // pix_x, pix_y, red, green, blue from the lowest bit up
  assign pix_word = {pal_rdata[4:0], 3'b000, pal_rdata[9:5], 3'b000,
                     pal_rdata[14:10], 3'b000, 16'(cur_y), 16'(cur_x)};

  always_comb begin
    pal_req.we    = s_fire && is_pal &&
                    ({1'b0, in_pal_index} < 13'(PALETTE_BANKS * BANK_SIZE));
    pal_req.waddr = in_pal_index;
    pal_req.wdata = s_axis_tdata[34:20];
    pal_req.re    = (state == S_DECODE) && !y_done && bank_ok && x_in &&
                    ((mode == MODE_LITERAL) ||
                     ((mode == MODE_REPEAT) && (run_length != 6'd0)));
    pal_req.raddr = {player_bank, byte_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mode          <= MODE_HEADER;
      cur_x         <= '0;
      cur_y         <= '0;
      run_remaining <= '0;
      run_length    <= '0;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_fire && !is_pal) begin
            byte_q <= s_axis_tdata[7:0];
            if (start) begin
              cur_x         <= '0;
              cur_y         <= '0;
              mode          <= MODE_HEADER;
              run_remaining <= '0;
              run_length    <= '0;
            end
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= S_IDLE;
          if (!y_done) begin
            if ((mode == MODE_HEADER) || lit_over) begin
              if (lit_over) begin
                mode          <= MODE_HEADER;
                run_remaining <= '0;
              end
              unique case (hdr_type)
                HDR_LITERAL: begin
                  if (x_in) begin
                    mode          <= MODE_LITERAL;
                    run_remaining <= hdr_len;
                  end
                end
                HDR_SKIP: begin
                  cnt   <= hdr_len;
                  state <= S_SKIP;
                end
                HDR_REPEAT: begin
                  mode       <= MODE_REPEAT;
                  run_length <= hdr_len;
                end
                HDR_NEWLINE: begin
                  cur_x <= '0;
                  cur_y <= cur_y + 1'b1;
                end
                default: begin
                end
              endcase
            end else if (mode == MODE_LITERAL) begin
              if (bank_ok) begin
                state <= S_LITPIX;
              end else begin
                cur_x         <= x_inc;
                run_remaining <= run_remaining - 6'd1;
                if (lit_end) begin
                  mode <= MODE_HEADER;
                end
              end
            end else begin
              if (bank_ok && x_in && (run_length != 6'd0)) begin
                cnt   <= '0;
                state <= S_RUN;
              end else begin
                mode       <= MODE_HEADER;
                run_length <= '0;
              end
            end
          end
        end
        S_SKIP: begin
          if ((cnt == 6'd0) || !x_in) begin
            state <= S_IDLE;
          end else begin
            cur_x <= x_inc;
            cnt   <= cnt - 6'd1;
          end
        end
        S_LITPIX: begin
          if (out_load) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= pix_word;
            m_axis_tlast  <= 1'b1;
            cur_x         <= x_inc;
            run_remaining <= run_remaining - 6'd1;
            if (lit_end) begin
              mode <= MODE_HEADER;
            end
            state <= S_IDLE;
          end
        end
        S_RUN: begin
          if (out_load) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= pix_word;
            m_axis_tlast  <= run_done;
            cur_x         <= x_inc;
            cnt           <= cnt_inc;
            if (run_done) begin
              mode       <= MODE_HEADER;
              run_length <= '0;
              state      <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_after_byte: assert property (@(posedge clk) disable iff (rst)
    (s_fire && !is_pal) |=> !s_axis_tready)
    else $error("stream byte accepted but sequencer still ready");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending pixel overwritten");

  a_pixel_in_line: assert property (@(posedge clk) disable iff (rst)
    out_load |-> x_in)
    else $error("pixel written beyond image width");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> ((cnt < run_length) && (run_length <= 6'd32)))
    else $error("repeat counter out of range");

endmodule
`default_nettype wire

@@ rtl/rle_palette_sprite_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rle_palette_sprite_decoder
// Run-length palette sprite decoder with RGB555 palette and 8-bit channels.
// ----------------------------------------------------------------------------
// A palette write leaves the input ready. A stream byte holds the input
// in the decode state after its transaction; a skip header then steps over
// the pixels skipped (the x stepper advances one pixel per cycle), a literal
// byte waits on the registered palette read, and a repeat index sends its
// pixels, one pixel per cycle while the pixel output is not back-pressured;
// any back-pressure on the pixel output holds these steps. The pixel output
// is registered, so the next byte is taken while the last pixel of a run
// still waits. Configuration is written through cfg_we / cfg_index /
// cfg_data and must only change while the decoder is idle.
module rle_palette_sprite_decoder
  import rlps_pkg::*;
#(
  parameter int PALETTE_BANKS = DEF_PALETTE_BANKS,
  parameter int COORD_BITS    = DEF_COORD_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // stream_byte, pal_index, pal_value, zero fill
  input  wire logic   [S_TDATA_BITS-1:0] s_axis_tdata,
  // req_type, start_image
  input  wire logic   [S_TUSER_BITS-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // pix_x, pix_y, red, green, blue
  output logic        [M_TDATA_BITS-1:0] m_axis_tdata,
  output logic                           m_axis_tlast,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic  [CFG_DATA_BITS-1:0] cfg_data
);

  logic [15:0]           image_width;
  logic [15:0]           image_height;
  logic [3:0]            player_bank;
  pal_req_t              pal_req;
  logic [COLOR_BITS-1:0] pal_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= '0;
      image_height <= '0;
      player_bank  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_PLAYER_BANK:  player_bank  <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  rlps_seq #(
    .PALETTE_BANKS (PALETTE_BANKS),
    .COORD_BITS    (COORD_BITS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .image_width   (image_width),
    .image_height  (image_height),
    .player_bank   (player_bank),
    .pal_req       (pal_req),
    .pal_rdata     (pal_rdata)
  );

  rlps_palette #(
    .PALETTE_BANKS (PALETTE_BANKS)
  ) u_palette (
    .clk   (clk),
    .req   (pal_req),
    .rdata (pal_rdata)
  );

endmodule
`default_nettype wire

@@ dv/sprite_pixel_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_pixel_checker
// Watches the configuration port and both stream channels of the sprite
// decoder. Every accepted input transaction is decoded by a local copy of the
// decoder state, which queues the pixels it should produce. Each accepted
// pixel transaction is compared field by field with the oldest queued pixel.
// ----------------------------------------------------------------------------
module sprite_pixel_checker
  import rlps_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  input  wire logic                      s_axis_tready,
  input  wire logic   [S_TDATA_BITS-1:0] s_axis_tdata,
  input  wire logic   [S_TUSER_BITS-1:0] s_axis_tuser,
  input  wire logic                      m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  input  wire logic   [M_TDATA_BITS-1:0] m_axis_tdata,
  input  wire logic                      m_axis_tlast,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic  [CFG_DATA_BITS-1:0] cfg_data,
  output int                             mismatch_count,
  output int                             pixels_pending
);

  localparam int NUM_ENTRIES = DEF_PALETTE_BANKS * BANK_SIZE;
  localparam int MAX_RUN     = 32;

  typedef enum logic [1:0] {
    DEC_HEADER,
    DEC_LITERAL,
    DEC_REPEAT
  } dec_mode_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } pixel_t;

  logic [COLOR_BITS-1:0] palette [NUM_ENTRIES];
  logic [15:0]           width;
  logic [15:0]           height;
  logic [3:0]            bank;
  logic [15:0]           cur_x;
  logic [15:0]           cur_y;
  dec_mode_t             mode;
  logic [5:0]            lit_left;
  logic [5:0]            rep_len;
  pixel_t                expected_pixels [$];
  int                    fails;

  initial begin
    fails = 0;
  end

  function automatic pixel_t shade(input logic [7:0] idx);
    logic [COLOR_BITS-1:0] c;
    pixel_t                p;
    c       = palette[{bank, idx}];
    p.x     = cur_x;
    p.y     = cur_y;
    p.red   = {c[14:10], 3'b000};
    p.green = {c[9:5], 3'b000};
    p.blue  = {c[4:0], 3'b000};
    p.last  = 1'b0;
    return p;
  endfunction

  task automatic decode_byte(input logic [S_TDATA_BITS-1:0] d,
                             input logic [S_TUSER_BITS-1:0] u);
    logic [7:0]  b;
    logic [11:0] pal_addr;
    logic [15:0] pal_word;
    logic [5:0]  len;
    logic        pal_write;
    logic        bank_ok;
    pixel_t      p;
    int          made;
    int          i;
    b         = d[7:0];
    pal_addr  = d[19:8];
    pal_word  = d[35:20];
    len       = {1'b0, b[4:0]} + 6'd1;
    pal_write = u[0];
    bank_ok   = (bank < DEF_PALETTE_BANKS);
    made      = 0;
    if (pal_write) begin
      if (pal_addr < NUM_ENTRIES) palette[pal_addr] = pal_word[14:0];
      return;
    end
    if (u[1]) begin
      cur_x    = '0;
      cur_y    = '0;
      mode     = DEC_HEADER;
      lit_left = '0;
      rep_len  = '0;
    end
    if (cur_y >= height) return;
    // width may have shrunk under a pending literal run
    if (mode == DEC_LITERAL && cur_x >= width) begin
      mode     = DEC_HEADER;
      lit_left = '0;
    end
    case (mode)
      DEC_HEADER: begin
        case (b[7:5])
          HDR_LITERAL: begin
            if (cur_x < width) begin
              mode     = DEC_LITERAL;
              lit_left = len;
            end
          end
          HDR_SKIP: begin
            for (i = 0; i < len && cur_x < width; i++) cur_x = cur_x + 16'd1;
          end
          HDR_REPEAT: begin
            mode    = DEC_REPEAT;
            rep_len = len;
          end
          HDR_NEWLINE: begin
            cur_x = '0;
            cur_y = cur_y + 16'd1;
          end
          default: ;
        endcase
      end
      DEC_LITERAL: begin
        if (bank_ok) begin
          expected_pixels = {expected_pixels, shade(b)};
          made++;
        end
        cur_x    = cur_x + 16'd1;
        lit_left = lit_left - 6'd1;
        if (lit_left == 0 || cur_x >= width) mode = DEC_HEADER;
      end
      default: begin
        if (bank_ok) begin
          for (i = 0; i < rep_len && i < MAX_RUN && cur_x < width; i++) begin
            expected_pixels = {expected_pixels, shade(b)};
            made++;
            cur_x = cur_x + 16'd1;
          end
        end
        mode    = DEC_HEADER;
        rep_len = '0;
      end
    endcase
    if (made > 0) begin
      p      = expected_pixels[expected_pixels.size() - 1];
      p.last = 1'b1;
      expected_pixels[expected_pixels.size() - 1] = p;
    end
  endtask

  task automatic check_pixel(input logic [M_TDATA_BITS-1:0] d, input logic l);
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      $error("unexpected pixel transaction x=%0d y=%0d", d[15:0], d[31:16]);
      fails++;
      return;
    end
    want = expected_pixels.pop_front();
    if (d[15:0] !== want.x) begin
      $error("pix_x expected %0d actual %0d", want.x, d[15:0]);
      fails++;
    end
    if (d[31:16] !== want.y) begin
      $error("pix_y expected %0d actual %0d", want.y, d[31:16]);
      fails++;
    end
    if (d[39:32] !== want.red) begin
      $error("red expected %0d actual %0d", want.red, d[39:32]);
      fails++;
    end
    if (d[47:40] !== want.green) begin
      $error("green expected %0d actual %0d", want.green, d[47:40]);
      fails++;
    end
    if (d[55:48] !== want.blue) begin
      $error("blue expected %0d actual %0d", want.blue, d[55:48]);
      fails++;
    end
    if (l !== want.last) begin
      $error("last_of_run expected %0d actual %0d", want.last, l);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width    = '0;
      height   = '0;
      bank     = '0;
      cur_x    = '0;
      cur_y    = '0;
      mode     = DEC_HEADER;
      lit_left = '0;
      rep_len  = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width  = cfg_data;
          REG_IMAGE_HEIGHT: height = cfg_data;
          REG_PLAYER_BANK:  bank   = cfg_data[3:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) check_pixel(m_axis_tdata, m_axis_tlast);
    end
    pixels_pending <= expected_pixels.size();
    mismatch_count <= fails;
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the run-length palette sprite decoder. Fills the
// last palette bank, runs a directed sprite covering every header type and
// clipping case, then random phases over several image sizes and banks with
// random gaps and receiver stalls, including one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import rlps_pkg::*;

  localparam logic REQ_STREAM  = 1'b0;
  localparam logic REQ_PALETTE = 1'b1;

  localparam int         NUM_ENTRIES   = DEF_PALETTE_BANKS * BANK_SIZE;
  localparam int         FILL_BASE     = (DEF_PALETTE_BANKS - 1) * BANK_SIZE;
  localparam logic [3:0] FILL_BANK     = 4'(DEF_PALETTE_BANKS - 1);
  localparam int         SETTLE_CYCLES = 64;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         HOLD_CYCLES   = 400;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic   [S_TDATA_BITS-1:0] s_axis_tdata = '0;
  logic   [S_TUSER_BITS-1:0] s_axis_tuser = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic   [M_TDATA_BITS-1:0] m_axis_tdata;
  logic                      m_axis_tlast;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic  [CFG_DATA_BITS-1:0] cfg_data = '0;

  int mismatch_count;
  int pixels_pending;
  int quiet_cycles = 0;
  int sent = 0;
  bit gaps_on = 1'b1;
  bit next_start = 1'b0;
  bit held_once = 1'b0;
  bit hold_req = 1'b0;
  bit steady = 1'b0;

  rle_palette_sprite_decoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  sprite_pixel_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pixels_pending (pixels_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // no transaction on any port for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // pixel receiver: random stalls, one long hold-off, one steady stretch
  initial begin
    forever begin
      @(posedge clk);
      if (!held_once && hold_req) begin
        held_once = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 20);
    end
  end

  task automatic send_item(input logic rtype, input logic first, input logic [7:0] b,
                           input logic [11:0] pidx, input logic [15:0] pval);
    if (gaps_on) begin
      while ($urandom_range(99) < 20) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, pval, pidx, b};
    s_axis_tuser  <= {first, rtype};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    logic [11:0] pidx;
    logic [15:0] pval;
    pidx = 12'($urandom_range(4095));
    pval = 16'($urandom_range(65535));
    send_item(REQ_STREAM, next_start, b, pidx, pval);
    next_start = 1'b0;
  endtask

  task automatic send_color(input logic [11:0] pidx, input logic [15:0] pval);
    logic [7:0] b;
    logic       first;
    b     = 8'($urandom_range(255));
    first = 1'($urandom_range(1));
    send_item(REQ_PALETTE, first, b, pidx, pval);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] w, input logic [15:0] h, input logic [3:0] bk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_PLAYER_BANK;
    cfg_data  <= {12'd0, bk};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int n_items);
    int         stop;
    int         kind;
    int         len;
    int         k;
    logic [4:0] r5;
    logic [7:0] r8;
    stop = sent + n_items;
    while (sent < stop) begin
      kind = $urandom_range(99);
      r5   = 5'($urandom_range(31));
      r8   = 8'($urandom_range(255));
      if (kind < 6) begin
        next_start = 1'b1;
      end else if (kind < 40) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(7);
        send_byte({HDR_LITERAL, len[4:0]});
        for (k = 0; k <= len; k++) send_byte(8'($urandom_range(255)));
      end else if (kind < 60) begin
        send_byte({HDR_REPEAT, r5});
        send_byte(r8);
      end else if (kind < 70) begin
        send_byte({HDR_SKIP, r5});
      end else if (kind < 77) begin
        send_byte({HDR_NEWLINE, r5});
      end else if (kind < 90) begin
        send_byte(r8);
      end else begin
        send_color(12'($urandom_range(4095)), 16'($urandom_range(65535)));
      end
    end
  endtask

  task automatic run_phase(input logic [15:0] w, input logic [15:0] h, input logic [3:0] bk,
                           input int n_items, input bit gaps, input bit hold);
    wait_drained();
    set_config(w, h, bk);
    gaps_on    = gaps;
    steady     = !gaps;
    next_start = ($urandom_range(9) != 0);
    if (hold) hold_req = 1'b1;
    random_phase(n_items);
    gaps_on = 1'b1;
    steady  = 1'b0;
  endtask

  initial begin
    int          a;
    int          t;
    logic [15:0] pv;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one whole bank; every lookup uses it or a bank that writes nothing
    for (a = 0; a < BANK_SIZE; a++) begin
      case (a)
        0:       pv = 16'h0000;
        1:       pv = 16'hFFFF;
        255:     pv = 16'h8000;
        default: pv = 16'($urandom_range(65535));
      endcase
      send_color(12'(FILL_BASE + a), pv);
    end
    send_color(12'(NUM_ENTRIES), 16'hFFFF);
    send_color(12'hFFF, 16'h7FFF);

    // directed sprite
    wait_drained();
    set_config(16'd40, 16'd4, FILL_BANK);
    next_start = 1'b1;
    send_byte({HDR_LITERAL, 5'd2});
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte({HDR_SKIP, 5'd4});
    send_byte({HDR_REPEAT, 5'd31});
    send_byte(8'h80);
    // line is full now
    send_byte({HDR_LITERAL, 5'd0});
    send_byte({HDR_REPEAT, 5'd1});
    send_byte(8'h11);
    send_byte({HDR_NEWLINE, 5'd31});
    for (t = 0; t < 8; t++) begin
      if (t != HDR_LITERAL && t != HDR_SKIP && t != HDR_REPEAT && t != HDR_NEWLINE) begin
        send_byte({t[2:0], 5'h1F});
      end
    end
    send_byte({HDR_SKIP, 5'd31});
    send_byte({HDR_SKIP, 5'd31});
    send_byte({HDR_NEWLINE, 5'd0});
    send_byte({HDR_NEWLINE, 5'd0});
    send_byte({HDR_NEWLINE, 5'd0});
    // height reached
    send_byte({HDR_LITERAL, 5'd0});
    send_byte(8'hFF);
    next_start = 1'b1;
    send_byte({HDR_LITERAL, 5'd31});
    send_byte(8'h01);
    send_byte(8'h02);
    // shrink the width under the pending literal run
    wait_drained();
    set_config(16'd1, 16'd4, FILL_BANK);
    send_byte({HDR_NEWLINE, 5'd0});
    send_byte({HDR_LITERAL, 5'd0});
    send_byte(8'h33);

    run_phase(16'd64, 16'd8, FILL_BANK, 50, 1'b1, 1'b1);
    run_phase(16'd0, 16'd12, FILL_BANK, 10, 1'b1, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, FILL_BANK, 40, 1'b0, 1'b0);
    run_phase(16'd24, 16'd0, FILL_BANK, 10, 1'b1, 1'b0);
    run_phase(16'd33, 16'd6, 4'(DEF_PALETTE_BANKS), 20, 1'b1, 1'b0);
    run_phase(16'd1, 16'd3, 4'hF, 15, 1'b1, 1'b0);
    run_phase(16'd48, 16'd5, FILL_BANK, 30, 1'b1, 1'b0);
    run_phase(16'd17, 16'hFFFF, FILL_BANK, 20, 1'b1, 1'b0);
    run_phase(16'd300, 16'd40, FILL_BANK, 20, 1'b1, 1'b0);

    wait_drained();
    if (mismatch_count == 0 && pixels_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/rlps_pkg.sv
rtl/rlps_palette.sv
rtl/rlps_seq.sv
rtl/rle_palette_sprite_decoder.sv
dv/sprite_pixel_checker.sv
dv/tb_top.sv
